[sv/depth_zone_near_distance_macros.svh]
// Assertion helpers used by the top-level RTL module.
`ifndef DEPTH_ZONE_NEAR_DISTANCE_MACROS_SVH
`define DEPTH_ZONE_NEAR_DISTANCE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DZN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define DZN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/dzn_pkg.sv]
`timescale 1ns / 1ps
package dzn_pkg;

  localparam int SZW      = 13;   // frame size math, covers sizes up to 8191
  localparam int DEPTH_W  = 16;
  localparam int DIST_W   = 14;
  localparam int COLS_W   = 11;
  localparam int ROWS_W   = 11;
  localparam int MARGIN_W = 10;
  localparam int CFG_W    = 16;
  localparam int NZONE    = 3;

  // floor(x/3) = (x * THIRD_MUL) >> SZW for x below 2**SZW
  localparam logic [SZW-2:0] THIRD_MUL = 12'd2731;

  localparam logic [COLS_W-1:0]   COLS_RST   = 11'd640;
  localparam logic [ROWS_W-1:0]   ROWS_RST   = 11'd480;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd96;
  localparam logic [CFG_W-1:0]    WARN_RST   = 16'd500;

  typedef enum logic [1:0] {
    CFG_COLS   = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_MARGIN = 2'd2,
    CFG_WARN   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic accept;       // latch item, read bin, advance position
    logic upd;          // write incremented bin
    logic sweep_start;  // begin bin sweep (scan and clear)
    logic load;         // capture result, clear counts
  } dzn_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic sweep_last;
    logic sweep_busy;
  } dzn_sts_t;

endpackage

[sv/depth_zone_near_distance.sv]
// Each depth item takes a bin read in S_IDLE, then a bin write in S_UPD; in_ready is low until the write.
// After the frame's last item come an update state, a sweep over every bin and a load state;
// the load, which raises out_valid, waits while the previous result is still unread.
// Reset: synchronous, active low; afterwards a clearing pass over every bin
// zeroes the histogram memories with in_ready low. Configuration writes are taken always.
`timescale 1ns / 1ps
`include "depth_zone_near_distance_macros.svh"
module depth_zone_near_distance #(
  parameter int MAX_COLS     = 1024,
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_DEPTH_MM = 10000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [dzn_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dzn_pkg::DEPTH_W-1:0] in_depth_mm,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dzn_pkg::DIST_W-1:0]  out_left_mm,
  output logic [dzn_pkg::DIST_W-1:0]  out_center_mm,
  output logic [dzn_pkg::DIST_W-1:0]  out_right_mm,
  output logic                        out_left_alert,
  output logic                        out_center_alert,
  output logic                        out_right_alert
);

  dzn_pkg::dzn_cmd_t cmd;
  dzn_pkg::dzn_sts_t sts;

  dzn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dzn_datapath #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_DEPTH_MM (MAX_DEPTH_MM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_depth_mm      (in_depth_mm),
    .cmd              (cmd),
    .sts              (sts),
    .out_left_mm      (out_left_mm),
    .out_center_mm    (out_center_mm),
    .out_right_mm     (out_right_mm),
    .out_left_alert   (out_left_alert),
    .out_center_alert (out_center_alert),
    .out_right_alert  (out_right_alert)
  );

  `DZN_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready, !in_ready)
  `DZN_ASSERT_NOW(a_no_item_in_sweep, sts.sweep_busy, !in_ready)
  `DZN_ASSERT_NOW(a_left_alert_dist, out_valid && out_left_alert, out_left_mm != '0)

endmodule

[sv/dzn_ctrl.sv]
`timescale 1ns / 1ps
module dzn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dzn_pkg::dzn_cmd_t cmd,
  input  dzn_pkg::dzn_sts_t sts
);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_CLR  = 6'b000010,
    S_IDLE = 6'b000100,
    S_UPD  = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept      = in_valid && (state_r == S_IDLE);
    cmd.upd         = (state_r == S_UPD);
    cmd.sweep_start = (state_r == S_INIT) || ((state_r == S_UPD) && sts.frame_end);
    cmd.load        = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: state_nxt = S_CLR;
      S_CLR:  if (sts.sweep_last) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_UPD;
      S_UPD:  state_nxt = sts.frame_end ? S_SCAN : S_IDLE;
      S_SCAN: if (sts.sweep_last) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/dzn_datapath.sv]
`timescale 1ns / 1ps
module dzn_datapath #(
  parameter int MAX_COLS     = 1024,
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_DEPTH_MM = 10000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [dzn_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [dzn_pkg::DEPTH_W-1:0] in_depth_mm,
  input  dzn_pkg::dzn_cmd_t           cmd,
  output dzn_pkg::dzn_sts_t           sts,
  output logic [dzn_pkg::DIST_W-1:0]  out_left_mm,
  output logic [dzn_pkg::DIST_W-1:0]  out_center_mm,
  output logic [dzn_pkg::DIST_W-1:0]  out_right_mm,
  output logic                        out_left_alert,
  output logic                        out_center_alert,
  output logic                        out_right_alert
);

  localparam int SZW = dzn_pkg::SZW;
  localparam int NZ  = dzn_pkg::NZONE;
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int HB  = MAX_DEPTH_MM + 1;
  localparam int AW  = $clog2(HB);
  localparam int NW  = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam logic [SZW-1:0] MAX_COLS_V = SZW'(MAX_COLS);
  localparam logic [SZW-1:0] MAX_ROWS_V = SZW'(MAX_ROWS);
  localparam logic [AW-1:0]  LAST_BIN   = AW'(MAX_DEPTH_MM);

  // configuration
  logic [dzn_pkg::COLS_W-1:0]   cols_r;
  logic [dzn_pkg::ROWS_W-1:0]   rows_r;
  logic [dzn_pkg::MARGIN_W-1:0] margin_r;
  logic [dzn_pkg::CFG_W-1:0]    warn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= dzn_pkg::COLS_RST;
      rows_r   <= dzn_pkg::ROWS_RST;
      margin_r <= dzn_pkg::MARGIN_RST;
      warn_r   <= dzn_pkg::WARN_RST;
    end else if (cfg_we) begin
      case (dzn_pkg::cfg_reg_t'(cfg_idx))
        dzn_pkg::CFG_COLS:   cols_r   <= cfg_wdata[dzn_pkg::COLS_W-1:0];
        dzn_pkg::CFG_ROWS:   rows_r   <= cfg_wdata[dzn_pkg::ROWS_W-1:0];
        dzn_pkg::CFG_MARGIN: margin_r <= cfg_wdata[dzn_pkg::MARGIN_W-1:0];
        dzn_pkg::CFG_WARN:   warn_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturated sizes and zone boundary
  logic [SZW-1:0]     cols_raw, rows_raw, cols_eff, rows_eff;
  logic [2*SZW-2:0]   third_prod;
  logic [SZW-2:0]     third_r;

  always_comb begin
    cols_raw = SZW'(cols_r);
    rows_raw = SZW'(rows_r);
    cols_eff = (cols_raw < SZW'(3)) ? SZW'(3) :
               ((cols_raw > MAX_COLS_V) ? MAX_COLS_V : cols_raw);
    rows_eff = (rows_raw < SZW'(1)) ? SZW'(1) :
               ((rows_raw > MAX_ROWS_V) ? MAX_ROWS_V : rows_raw);
    third_prod = cols_eff * dzn_pkg::THIRD_MUL;
  end

  always_ff @(posedge clk) begin
    third_r <= third_prod[2*SZW-2:SZW];
  end

  // position tracking
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [SZW:0]   col_e, row_e, m_e, cols_e, rows_e, col_inc, row_inc, third_e;
  logic           in_band, dval, wrap, fend;
  logic [NZ-1:0]  zone_sel;
  logic           frame_end_r;
  logic [NZ-1:0]  zone_r;
  logic [AW-1:0]  upd_addr_r;

  always_comb begin
    col_e   = (SZW+1)'(col_r);
    row_e   = (SZW+1)'(row_r);
    m_e     = (SZW+1)'(margin_r);
    cols_e  = (SZW+1)'(cols_eff);
    rows_e  = (SZW+1)'(rows_eff);
    third_e = (SZW+1)'(third_r);
    in_band = (row_e >= m_e) && ((m_e << 1) < rows_e) && ((row_e + m_e) < rows_e);
    dval    = (in_depth_mm != '0) &&
              (in_depth_mm <= dzn_pkg::DEPTH_W'(MAX_DEPTH_MM));
    zone_sel[0] = col_e < third_e;
    zone_sel[1] = !zone_sel[0] && (col_e < (third_e << 1));
    zone_sel[2] = !zone_sel[0] && !zone_sel[1];
    if (!(in_band && dval)) zone_sel = '0;
    col_inc = col_e + (SZW+1)'(1);
    wrap    = col_inc >= cols_e;
    row_inc = row_e + (SZW+1)'(wrap);
    fend    = row_inc >= rows_e;
    col_nxt = (wrap || fend) ? '0 : col_inc[CW-1:0];
    row_nxt = fend ? '0 : row_inc[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      frame_end_r <= 1'b0;
      zone_r      <= '0;
    end else if (cmd.accept) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      frame_end_r <= fend;
      zone_r      <= zone_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) upd_addr_r <= AW'(in_depth_mm);
  end

  // bin sweep: read every bin, write it back as zero in the following cycle
  logic          sw_act_r, sw_v_r;
  logic [AW-1:0] sw_addr_r, sw_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_act_r <= 1'b0;
      sw_v_r   <= 1'b0;
    end else begin
      sw_v_r <= sw_act_r;
      if (cmd.sweep_start) begin
        sw_act_r <= 1'b1;
      end else if (sw_act_r && (sw_addr_r == LAST_BIN)) begin
        sw_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_tag_r <= sw_addr_r;
    if (cmd.sweep_start) sw_addr_r <= '0;
    else if (sw_act_r)   sw_addr_r <= sw_addr_r + AW'(1);
  end

  assign sts.frame_end  = frame_end_r;
  assign sts.sweep_last = sw_v_r && (sw_tag_r == LAST_BIN);
  assign sts.sweep_busy = sw_act_r || sw_v_r;

  // histogram read data, one per zone
  logic [NW-1:0] rdata_r [NZ];
  logic [AW-1:0] raddr, waddr;

  assign raddr = sw_act_r ? sw_addr_r : AW'(in_depth_mm);
  assign waddr = sw_v_r ? sw_tag_r : upd_addr_r;

  // per-zone counts and percentile search
  logic [NW-1:0]    cnt_r [NZ];
  logic [NW-1:0]    cum_r [NZ];
  logic [NW-1:0]    cum_nxt [NZ];
  logic [NW+4:0]    cum20 [NZ];
  logic             found_r [NZ];
  logic [AW-1:0]    val_r [NZ];
  logic [dzn_pkg::DIST_W-1:0] zone_mm [NZ];
  logic             alert [NZ];

  for (genvar z = 0; z < NZ; z++) begin : g_zone
    logic [NW-1:0] hist_mem [HB];

    always_ff @(posedge clk) begin
      if (sw_v_r) begin
        hist_mem[waddr] <= '0;
      end else if (cmd.upd && zone_r[z]) begin
        hist_mem[waddr] <= rdata_r[z] + NW'(1);
      end
      rdata_r[z] <= hist_mem[raddr];
    end

    always_comb begin
      cum_nxt[z] = cum_r[z] + rdata_r[z];
      // floor(n/20) < cum  <=>  n < 20*cum
      cum20[z]   = ((NW+5)'(cum_nxt[z]) << 4) + ((NW+5)'(cum_nxt[z]) << 2);
      zone_mm[z] = dzn_pkg::DIST_W'(val_r[z]);
      alert[z]   = (val_r[z] != '0) && (dzn_pkg::CFG_W'(val_r[z]) < warn_r);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[z] <= '0;
      end else if (cmd.load) begin
        cnt_r[z] <= '0;
      end else if (cmd.upd && zone_r[z]) begin
        cnt_r[z] <= cnt_r[z] + NW'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.sweep_start) begin
        cum_r[z]   <= '0;
        found_r[z] <= 1'b0;
        val_r[z]   <= '0;
      end else if (sw_v_r && !found_r[z]) begin
        cum_r[z] <= cum_nxt[z];
        if ((sw_tag_r != '0) && (cum20[z] > (NW+5)'(cnt_r[z]))) begin
          found_r[z] <= 1'b1;
          val_r[z]   <= sw_tag_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_left_mm      <= zone_mm[0];
      out_center_mm    <= zone_mm[1];
      out_right_mm     <= zone_mm[2];
      out_left_alert   <= alert[0];
      out_center_alert <= alert[1];
      out_right_alert  <= alert[2];
    end
  end

endmodule
